@@ hdl/serial_command_frame_parser_top_defines.svh @@
// Assertion macros used by the serial command frame parser top level
`ifndef SERIAL_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle
`define SCFP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the following cycle
`define SCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/scfp_pkg.sv @@
// Shared types and constants of the serial command frame parser
package scfp_pkg;

	// Number of entries in the result queue
	localparam logic [1:0] QDepth = 2'd2;

	// Frame result status codes
	typedef enum logic [1:0] {
		ST_GOOD   = 2'd0,
		ST_BADSUM = 2'd1,
		ST_LENERR = 2'd2
	} status_t;

	// One parsed frame result
	typedef struct packed {
		status_t    status;
		logic [7:0] command;
		logic [7:0] data_high;
		logic [7:0] data_low;
		logic [1:0] data_count;
	} result_t;

	// Write request from the parser into the result queue
	typedef struct packed {
		logic    valid;
		result_t res;
	} push_t;

	// Queue status seen by the parser and the output stage
	typedef struct packed {
		logic    full;
		logic    head_valid;
		result_t head;
	} q_stat_t;

endpackage

@@ hdl/serial_command_frame_parser_top.sv @@
// Serial command frame parser: top level
// Usage:
//   Received bytes enter on rx_byte with in_valid; a byte is taken at a clock
//   edge where in_valid is high and in_stall is low. One byte per cycle is
//   accepted back to back; in_stall rises only when the two-entry result
//   queue is full, which needs the receiver to stall for several results.
//   Frames are start, length, command, up to two data bytes, checksum.
//   Each finished frame or length error gives one transaction on the output
//   channel (status, command, data_high, data_low, data_count), taken at an
//   edge where out_valid is high and out_stall is low. The result reaches
//   the output register at the edge after the closing byte is accepted unless a
//   stall or older result holds it. While out_stall is high the result holds;
//   later results wait in the queue and the parser keeps taking bytes until
//   the queue fills. start_byte is written through cfg_valid/cfg_ready
//   (always ready); the user must write it only while idle, unenforced here.
//   Reset clears the parser to hunting, the start byte to zero and empties
//   the queue and output register; no clearing pass is needed.
`include "serial_command_frame_parser_top_defines.svh"

module serial_command_frame_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] start_byte,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] command,
	output logic [7:0] data_high,
	output logic [7:0] data_low,
	output logic [1:0] data_count
);

	scfp_pkg::push_t   push;
	scfp_pkg::q_stat_t q_stat;
	scfp_pkg::result_t out_res;
	logic              pop;

	scfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.start_byte (start_byte),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.q_full     (q_stat.full),
		.push       (push)
	);

	scfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (q_stat)
	);

	scfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status     = out_res.status;
	assign command    = out_res.command;
	assign data_high  = out_res.data_high;
	assign data_low   = out_res.data_low;
	assign data_count = out_res.data_count;

	// Parser never writes into a full queue
	`SCFP_ASSERT_SAME(a_push_not_full, push.valid, !q_stat.full, "push into full queue")
	// A full queue always has a head to offer
	`SCFP_ASSERT_SAME(a_full_has_head, q_stat.full, q_stat.head_valid, "full queue without head")
	// A taken result with nothing queued leaves the output empty
	`SCFP_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !q_stat.head_valid, !out_valid, "output not emptied")

endmodule

@@ hdl/scfp_queue.sv @@
// Two-entry result queue between the parser and the output stage
module scfp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  scfp_pkg::push_t   push,
	input  logic              pop,
	output scfp_pkg::q_stat_t stat
);

	logic [1:0]        count_q;
	scfp_pkg::result_t head_q;
	scfp_pkg::result_t tail_q;

	assign stat.full       = (count_q == scfp_pkg::QDepth);
	assign stat.head_valid = (count_q != 2'd0);
	assign stat.head       = head_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Move entries: head takes the tail or a fresh write
	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == scfp_pkg::QDepth) begin
				head_q <= tail_q;
			end else if (push.valid) begin
				head_q <= push.res;
			end
		end else if (push.valid) begin
			if (count_q == 2'd0) begin
				head_q <= push.res;
			end else begin
				tail_q <= push.res;
			end
		end
	end

endmodule

@@ hdl/scfp_front.sv @@
// Frame parser: classifies each received byte and posts finished frames
module scfp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [7:0]      start_byte,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	input  logic            q_full,
	output scfp_pkg::push_t push
);

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_CMD  = 3'd2,
		PH_DATA = 3'd3,
		PH_CSUM = 3'd4
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] start_q;
	logic [7:0] left_q, left_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] dh_q, dh_d;
	logic [7:0] dl_q, dl_d;
	logic [1:0] cnt_q, cnt_d;
	logic       accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	// Next-state decode for one byte
	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		sum_d      = sum_q;
		cmd_d      = cmd_q;
		dh_d       = dh_q;
		dl_d       = dl_q;
		cnt_d      = cnt_q;
		push.valid = 1'b0;
		push.res   = '{status: scfp_pkg::ST_GOOD, command: cmd_q, data_high: dh_q,
			data_low: dl_q, data_count: cnt_q};
		unique case (phase_q)
			PH_LEN: begin
				left_d  = rx_byte;
				sum_d   = sum_q + rx_byte;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				sum_d   = sum_q + rx_byte;
				left_d  = left_q - 8'd1;
				phase_d = PH_DATA;
			end
			PH_DATA: begin
				priority if (left_q == 8'd0) begin
					push.valid      = 1'b1;
					push.res.status = (rx_byte == sum_q) ? scfp_pkg::ST_GOOD
						: scfp_pkg::ST_BADSUM;
					phase_d = PH_HUNT;
					left_d  = 8'd0;
					sum_d   = 8'd0;
				end else if (left_q == 8'd2) begin
					dh_d   = rx_byte;
					cnt_d  = 2'd1;
					sum_d  = sum_q + rx_byte;
					left_d = 8'd1;
				end else if (left_q == 8'd1) begin
					dl_d    = rx_byte;
					cnt_d   = cnt_q + 2'd1;
					sum_d   = sum_q + rx_byte;
					left_d  = 8'd0;
					phase_d = PH_CSUM;
				end else begin
					// Length error: drop the byte and report
					push.valid = 1'b1;
					push.res   = '{status: scfp_pkg::ST_LENERR, command: cmd_q,
						data_high: 8'd0, data_low: 8'd0, data_count: 2'd0};
					phase_d = PH_HUNT;
					left_d  = 8'd0;
					sum_d   = 8'd0;
				end
			end
			PH_CSUM: begin
				push.valid      = 1'b1;
				push.res.status = (rx_byte == sum_q) ? scfp_pkg::ST_GOOD
					: scfp_pkg::ST_BADSUM;
				phase_d = PH_HUNT;
				left_d  = 8'd0;
				sum_d   = 8'd0;
			end
			default: begin
				// Hunt for the start byte; clear captured fields on a match
				if (rx_byte == start_q) begin
					phase_d = PH_LEN;
					left_d  = 8'd0;
					sum_d   = 8'd0;
					cmd_d   = 8'd0;
					dh_d    = 8'd0;
					dl_d    = 8'd0;
					cnt_d   = 2'd0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
		push.valid = push.valid && accept;
	end

	// Hold parser state; advance on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			start_q <= 8'd0;
			left_q  <= 8'd0;
			sum_q   <= 8'd0;
			cmd_q   <= 8'd0;
			dh_q    <= 8'd0;
			dl_q    <= 8'd0;
			cnt_q   <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				start_q <= start_byte;
			end
			if (accept) begin
				phase_q <= phase_d;
				left_q  <= left_d;
				sum_q   <= sum_d;
				cmd_q   <= cmd_d;
				dh_q    <= dh_d;
				dl_q    <= dl_d;
				cnt_q   <= cnt_d;
			end
		end
	end

endmodule

@@ hdl/scfp_back.sv @@
// Output stage: registers the queue head and presents it to the receiver
module scfp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  scfp_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output scfp_pkg::result_t out_res
);

	logic              out_valid_q;
	scfp_pkg::result_t out_q;
	logic              take;

	assign take      = !out_valid_q || !out_stall;
	assign pop       = take && q_stat.head_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Load a new result once the current one has gone or none is shown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= q_stat.head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_stat.head;
		end
	end

endmodule

@@ tb/sv/scfp_checker.sv @@
// Frame parser checker: watches all channels, predicts frame results and compares them
module scfp_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] start_byte,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] status,
	input  logic [7:0] command,
	input  logic [7:0] data_high,
	input  logic [7:0] data_low,
	input  logic [1:0] data_count,
	output int         fail_count,
	output int         pending
);

	// Parser position within a frame
	typedef enum logic [2:0] {
		PH_HUNT     = 3'd0,
		PH_LENGTH   = 3'd1,
		PH_COMMAND  = 3'd2,
		PH_DATA     = 3'd3,
		PH_CHECKSUM = 3'd4
	} phase_t;

	phase_t            phase;
	logic [7:0]        frame_start;
	logic [7:0]        remaining;
	logic [7:0]        csum;
	logic [7:0]        cmd_seen;
	logic [7:0]        dhi_seen;
	logic [7:0]        dlo_seen;
	logic [1:0]        ndata_seen;
	scfp_pkg::result_t frames_due[$];

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string msg);
		$display("scfp_checker: %s", msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Drop back to hunting for the start byte
	task automatic rehunt;
		phase = PH_HUNT;
		remaining = 8'd0;
		csum = 8'd0;
	endtask

	// Closing byte: compare against the running sum and queue the result
	task automatic close_frame(input logic [7:0] b);
		scfp_pkg::result_t r;
		r.status = (b == csum) ? scfp_pkg::ST_GOOD : scfp_pkg::ST_BADSUM;
		r.command = cmd_seen;
		r.data_high = dhi_seen;
		r.data_low = dlo_seen;
		r.data_count = ndata_seen;
		frames_due.push_back(r);
		rehunt();
	endtask

	// Advance the frame state by one received byte
	task automatic parse_byte(input logic [7:0] b);
		scfp_pkg::result_t r;
		case (phase)
			PH_LENGTH: begin
				remaining = b;
				csum = csum + b;
				phase = PH_COMMAND;
			end
			PH_COMMAND: begin
				cmd_seen = b;
				csum = csum + b;
				remaining = remaining - 8'd1;
				phase = PH_DATA;
			end
			PH_DATA: begin
				if (remaining == 8'd0) begin
					close_frame(b);
				end else if (remaining == 8'd2) begin
					dhi_seen = b;
					ndata_seen = 2'd1;
					csum = csum + b;
					remaining = 8'd1;
				end else if (remaining == 8'd1) begin
					dlo_seen = b;
					ndata_seen = ndata_seen + 2'd1;
					csum = csum + b;
					remaining = 8'd0;
					phase = PH_CHECKSUM;
				end else begin
					// Length out of range: discard the byte, report the command only
					r.status = scfp_pkg::ST_LENERR;
					r.command = cmd_seen;
					r.data_high = 8'd0;
					r.data_low = 8'd0;
					r.data_count = 2'd0;
					frames_due.push_back(r);
					rehunt();
				end
			end
			PH_CHECKSUM: begin
				close_frame(b);
			end
			default: begin
				if (b == frame_start) begin
					phase = PH_LENGTH;
					remaining = 8'd0;
					csum = 8'd0;
					cmd_seen = 8'd0;
					dhi_seen = 8'd0;
					dlo_seen = 8'd0;
					ndata_seen = 2'd0;
				end else begin
					phase = PH_HUNT;
				end
			end
		endcase
	endtask

	// Compare one delivered result with the oldest one due
	task automatic take_result;
		scfp_pkg::result_t want;
		if (frames_due.size() == 0) begin
			report_mismatch($sformatf("result with nothing due, status %0d command %0h",
				status, command));
		end else begin
			want = frames_due.pop_front();
			check_field("status", {6'd0, status}, {6'd0, want.status});
			check_field("command", command, want.command);
			check_field("data_high", data_high, want.data_high);
			check_field("data_low", data_low, want.data_low);
			check_field("data_count", {6'd0, data_count}, {6'd0, want.data_count});
		end
	endtask

	// Track register writes, accepted bytes and delivered results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start = 8'd0;
			cmd_seen = 8'd0;
			dhi_seen = 8'd0;
			dlo_seen = 8'd0;
			ndata_seen = 2'd0;
			rehunt();
			frames_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				frame_start = start_byte;
			if (in_valid && !in_stall)
				parse_byte(rx_byte);
			if (out_valid && !out_stall)
				take_result();
			pending <= frames_due.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Frame parser testbench top: clock, reset, byte stimulus, receiver stalls and verdict
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_BYTES = 350;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] start_byte = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] status;
	logic [7:0] command;
	logic [7:0] data_high;
	logic [7:0] data_low;
	logic [1:0] data_count;

	int         fail_count;
	int         pending;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         bytes_sent = 0;
	logic [7:0] cur_start = 8'd0;

	serial_command_frame_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.start_byte(start_byte),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.command(command),
		.data_high(data_high),
		.data_low(data_low),
		.data_count(data_count)
	);

	scfp_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.start_byte(start_byte),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.command(command),
		.data_high(data_high),
		.data_low(data_low),
		.data_count(data_count),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Free-running clock
	initial begin
		forever #4 clk = ~clk;
	end

	// Random receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Give up on a hung run
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	// Offer one byte after a random idle gap and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// One frame; lengths outside 1..3 send a single byte after the command
	task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
			input logic [7:0] dh, input logic [7:0] dl, input bit corrupt);
		logic [7:0] sum;
		send_byte(cur_start);
		send_byte(len);
		send_byte(cmd);
		sum = len + cmd;
		if (len == 8'd0 || len > 8'd3) begin
			send_byte(dh);
			return;
		end
		if (len == 8'd3) begin
			send_byte(dh);
			sum = sum + dh;
		end
		if (len >= 8'd2) begin
			send_byte(dl);
			sum = sum + dl;
		end
		send_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
	endtask

	// Stop sending and wait until every due result has been taken
	task automatic wait_drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start(input logic [7:0] v);
		cfg_valid <= 1'b1;
		start_byte <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_start = v;
	endtask

	// Mostly well-formed frames, with length errors, cut-off frames and noise
	task automatic run_traffic(input int target);
		int pick;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				send_frame(8'($urandom_range(1, 3)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					$urandom_range(99) < 15);
			end else if (pick < 82) begin
				send_frame(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(4, 255)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, 1'b0);
			end else if (pick < 86) begin
				send_byte(cur_start);
				send_byte(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
			end
			// Now and then hold off until the output side has caught up
			if ($urandom_range(99) < 2)
				wait_drain();
		end
	endtask

	// Reset, directed frames, then random phases under several settings
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: start byte still at its reset value of zero
		send_frame(8'd1, 8'hFF, 8'd0, 8'd0, 1'b0);
		send_frame(8'd3, 8'hA5, 8'hFF, 8'h00, 1'b0);
		send_frame(8'd2, 8'h3C, 8'd0, 8'h81, 1'b1);
		send_frame(8'd0, 8'h77, 8'hE1, 8'd0, 1'b0);
		send_frame(8'd4, 8'h12, 8'h5E, 8'd0, 1'b0);
		send_byte(8'h5A);
		send_frame(8'd1, 8'h00, 8'd0, 8'd0, 1'b0);
		wait_drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					write_start(8'hFF);
				end
				1: begin
					idle_pct = 80;
					stall_pct = 0;
					write_start(8'($urandom_range(255)));
				end
				2: begin
					idle_pct = 0;
					stall_pct = 80;
					write_start(8'h00);
				end
				default: begin
					idle_pct = 7;
					stall_pct = 7;
					write_start(8'($urandom_range(255)));
				end
			endcase
			run_traffic(bytes_sent + PHASE_BYTES);
			wait_drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/scfp_pkg.sv
hdl/scfp_queue.sv
hdl/scfp_front.sv
hdl/scfp_back.sv
hdl/serial_command_frame_parser_top.sv
tb/sv/scfp_checker.sv
tb/sv/tb_top.sv
